// ===== rtl/core/yaw_heading_correction_pd_unit_defines.svh =====
// Assertion macros shared by the yaw heading correction design.
`ifndef YAW_HEADING_CORRECTION_PD_UNIT_DEFINES_SVH
`define YAW_HEADING_CORRECTION_PD_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define YHC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define YHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/yhc_pkg.sv =====
package yhc_pkg;

  // Field and datapath types.
  typedef logic signed [15:0] angle_t;
  typedef logic signed [17:0] wrap_t;
  typedef logic        [14:0] mag_t;
  typedef logic        [15:0] tick_t;
  typedef logic signed [15:0] drive_t;
  typedef logic signed [16:0] diff_t;
  typedef logic signed [20:0] mac_arg_t;
  typedef logic signed [41:0] prod_t;
  typedef logic signed [17:0] num_t;
  typedef logic        [19:0] round_t;
  typedef logic        [12:0] gain_t;
  typedef logic        [1:0]  settle_t;
  typedef logic        [1:0]  cfg_idx_t;
  typedef logic        [15:0] cfg_data_t;

  localparam int QUOT_W      = 15;
  localparam int RECIP_SHIFT = 24;

  // Command codes of an input transaction.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes.
  localparam cfg_idx_t REG_TARGET_HEADING = 2'd0;
  localparam cfg_idx_t REG_TICK_LIMIT     = 2'd1;

  typedef enum logic [2:0] {
    STATUS_IDLE      = 3'd0,
    STATUS_RUNNING   = 3'd1,
    STATUS_SKIPPED   = 3'd2,
    STATUS_SETTLED   = 3'd3,
    STATUS_TIMED_OUT = 3'd4
  } status_t;

  // Angles in 1/128 degree.
  localparam wrap_t HALF_TURN     = 18'sd23040;
  localparam wrap_t NEG_HALF_TURN = -18'sd23040;
  localparam wrap_t FULL_TURN     = 18'sd46080;
  localparam angle_t ERR_MAX      = 16'sd23040;
  localparam angle_t ERR_MIN      = -16'sd23040;
  localparam mag_t TOL_COARSE     = 15'd192;
  localparam mag_t TOL_FINE       = 15'd102;
  localparam mag_t SWITCH_ERR     = 15'd640;
  localparam mag_t WIDE_ERR       = 15'd1280;

  localparam settle_t SETTLE_TICKS = 2'd3;
  localparam settle_t SETTLE_MAX   = 2'd3;
  localparam tick_t TICK_LIMIT_RESET = 16'd60;

  // Gains scaled by five, with dt and the unit change folded in.
  localparam gain_t KP5_FAST    = 13'd1280;
  localparam gain_t KD5_FAST    = 13'd2560;
  localparam gain_t KP5_SWITCH  = 13'd768;
  localparam gain_t KD5_SWITCH  = 13'd5120;
  localparam gain_t KP5_PRECISE = 13'd512;
  localparam gain_t KD5_PRECISE = 13'd7680;

  // Raw numerator clamp, smoothing and rounding constants.
  localparam prod_t NUM_MAX       = 42'sd65536;
  localparam prod_t NUM_MIN       = -42'sd65536;
  localparam num_t  NUM_CLAMP     = 18'sd65536;
  localparam num_t  NUM_CLAMP_NEG = -18'sd65536;
  localparam mac_arg_t SMOOTH_NUM   = 21'sd7;
  localparam mac_arg_t SMOOTH_PRIOR = 21'sd15;
  localparam round_t ROUND_BIAS     = 20'd25;
  // ceil(2^24 / 25): exact floor division by 25 for operands below 2^19.
  localparam mac_arg_t RECIP_25     = 21'sd671089;

  // Output limits in 1/32768 full scale.
  localparam drive_t LIM_LOW      = 16'sd13107;
  localparam drive_t LIM_HIGH     = 16'sd19661;
  localparam drive_t NEG_LIM_HIGH = -16'sd19661;

  // One operation of the shared multiply-accumulate unit.
  typedef struct packed {
    logic     en;
    logic     accumulate;
    mac_arg_t a;
    mac_arg_t b;
  } mac_op_t;

endpackage

// ===== rtl/core/yhc_if.sv =====
// Input channel: one command with its yaw sample.
interface yhc_in_if;
  logic                valid;
  logic                ready;
  logic                command;
  yhc_pkg::angle_t     yaw_sample;

  modport source (output valid, command, yaw_sample, input ready);
  modport sink (input valid, command, yaw_sample, output ready);
endinterface

// Result channel: drive command, run status and wrapped error.
interface yhc_out_if;
  logic                valid;
  logic                ready;
  yhc_pkg::drive_t     turn_rate_cmd;
  logic [2:0]          run_status;
  yhc_pkg::angle_t     heading_error;

  modport source (output valid, turn_rate_cmd, run_status, heading_error, input ready);
  modport sink (input valid, turn_rate_cmd, run_status, heading_error, output ready);
endinterface

// Configuration write channel.
interface yhc_cfg_if;
  logic                valid;
  logic                ready;
  yhc_pkg::cfg_idx_t   index;
  yhc_pkg::cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/yaw_heading_correction_pd_unit.sv =====
// Yaw heading correction unit: a gain-scheduled PD controller with output
// smoothing. A start transaction (command 0) opens a run toward the configured
// target heading, or reports it skipped when the yaw is already within 1.5
// degrees; each tick transaction (command 1) carries one yaw sample and returns
// one result with the turn-rate command, the run status and the wrapped error.
// Angles are in 1/128 degree, the turn command in 1/32768 full scale. Items are
// taken one at a time: a start, idle, timed-out, settling or first-step item
// passes only through the wrap, evaluation and output steps, and any other tick
// also through the PD steps, with a further wrap step when the error needs its
// full-turn wrap correction. A result held by the receiver adds stall cycles.
// The PD step is set by the single shared multiply-accumulate unit, which
// forms the two gain products, the smoothing sum and the divide by fifty one
// after another. A finished result waits in an output register while the next
// transaction is accepted. Configuration writes are taken at any time; a write
// made while no item is in flight applies from the next item.
module yaw_heading_correction_pd_unit (
  input  logic      clk,
  input  logic      rst,
  yhc_in_if.sink    item,
  yhc_out_if.source result,
  yhc_cfg_if.sink   cfg
);

  yhc_pkg::angle_t  target_heading;
  yhc_pkg::tick_t   tick_limit;
  yhc_pkg::mac_op_t mac_op;
  yhc_pkg::prod_t   mac_acc;

  assign cfg.ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_heading <= '0;
      tick_limit     <= yhc_pkg::TICK_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        yhc_pkg::REG_TARGET_HEADING: begin
          target_heading <= cfg.data;
        end
        yhc_pkg::REG_TICK_LIMIT: begin
          tick_limit <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  yhc_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .result         (result),
    .target_heading (target_heading),
    .tick_limit     (tick_limit),
    .mac_op         (mac_op),
    .mac_acc        (mac_acc)
  );

  yhc_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (mac_acc)
  );

endmodule

// ===== rtl/core/yhc_mac.sv =====
// Shared signed multiply-accumulate unit with a registered accumulator.
module yhc_mac (
  input  logic             clk,
  input  yhc_pkg::mac_op_t op,
  output yhc_pkg::prod_t   acc
);

  yhc_pkg::prod_t product;
  yhc_pkg::prod_t acc_next;

  // One 21 x 21 signed product per cycle.
  assign product  = op.a * op.b;
  assign acc_next = (op.accumulate ? acc : '0) + product;

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= acc_next;
    end
  end

endmodule

// ===== rtl/core/yhc_seq.sv =====
`include "yaw_heading_correction_pd_unit_defines.svh"

// Sequencer: error wrap, run bookkeeping, gain schedule and the PD step
// driven through the shared multiply-accumulate unit.
module yhc_seq (
  input  logic             clk,
  input  logic             rst,
  yhc_in_if.sink           item,
  yhc_out_if.source        result,
  input  yhc_pkg::angle_t  target_heading,
  input  yhc_pkg::tick_t   tick_limit,
  output yhc_pkg::mac_op_t mac_op,
  input  yhc_pkg::prod_t   mac_acc
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_EVAL,
    S_MUL_P,
    S_MUL_D,
    S_CLAMP,
    S_SMOOTH_N,
    S_SMOOTH_P,
    S_ROUND,
    S_DIVIDE,
    S_FINISH,
    S_OUT
  } state_t;

  state_t state;

  // Run state.
  logic                run_active;
  logic                coarse_mode;
  yhc_pkg::settle_t    settle_count;
  yhc_pkg::tick_t      elapsed_ticks;
  logic                first_step;
  yhc_pkg::angle_t     prior_error;
  yhc_pkg::drive_t     prior_drive;

  // Working registers of one item.
  logic                cmd;
  yhc_pkg::wrap_t      wrap;
  yhc_pkg::gain_t      kp;
  yhc_pkg::gain_t      kd;
  yhc_pkg::diff_t      diff;
  yhc_pkg::num_t       num_c;
  logic                neg;
  yhc_pkg::round_t     mag;
  yhc_pkg::drive_t     drive;
  yhc_pkg::status_t    status;

  // Output register.
  logic                out_valid;
  yhc_pkg::drive_t     out_drive;
  yhc_pkg::status_t    out_status;
  yhc_pkg::angle_t     out_err;
  logic                out_load;

  // Derived values.
  yhc_pkg::angle_t     err;
  yhc_pkg::mag_t       aerr;
  logic                in_tol;
  yhc_pkg::settle_t    settle_inc;
  yhc_pkg::settle_t    settle_new;
  logic                settled;
  yhc_pkg::mac_arg_t   acc_low;
  yhc_pkg::mac_arg_t   acc_abs;
  logic [yhc_pkg::QUOT_W-1:0] quot;
  yhc_pkg::drive_t     smooth;
  yhc_pkg::drive_t     lim;
  yhc_pkg::drive_t     lim_neg;

  assign err        = wrap[15:0];
  assign aerr       = err[15] ? yhc_pkg::mag_t'(-err) : yhc_pkg::mag_t'(err);
  assign in_tol     = aerr <= (coarse_mode ? yhc_pkg::TOL_COARSE : yhc_pkg::TOL_FINE);
  assign settle_inc = (settle_count < yhc_pkg::SETTLE_MAX) ? settle_count + 2'd1
                                                           : settle_count;
  assign settle_new = in_tol ? settle_inc : '0;
  assign settled    = in_tol && (settle_new >= yhc_pkg::SETTLE_TICKS);

  // Rounding helpers: magnitude of the smoothed sum and the scaled quotient.
  assign acc_low = mac_acc[20:0];
  assign acc_abs = acc_low[20] ? -acc_low : acc_low;
  assign quot    = mac_acc[yhc_pkg::RECIP_SHIFT +: yhc_pkg::QUOT_W];
  assign smooth  = neg ? -yhc_pkg::drive_t'({1'b0, quot}) : yhc_pkg::drive_t'({1'b0, quot});
  assign lim     = (aerr > yhc_pkg::WIDE_ERR) ? yhc_pkg::LIM_HIGH : yhc_pkg::LIM_LOW;
  assign lim_neg = -lim;

  // The finished result moves into the output register once it is free.
  assign out_load = (state == S_OUT) && (!out_valid || result.ready);

  assign item.ready            = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.turn_rate_cmd  = out_drive;
  assign result.run_status     = out_status;
  assign result.heading_error  = out_err;

  // Operation issued to the shared unit in each step.
  always_comb begin
    mac_op = '0;
    case (state)
      S_MUL_P: begin
        mac_op.en = 1'b1;
        mac_op.a  = $signed({8'b0, kp});
        mac_op.b  = yhc_pkg::mac_arg_t'(err);
      end
      S_MUL_D: begin
        mac_op.en         = 1'b1;
        mac_op.accumulate = 1'b1;
        mac_op.a          = $signed({8'b0, kd});
        mac_op.b          = yhc_pkg::mac_arg_t'(diff);
      end
      S_SMOOTH_N: begin
        mac_op.en = 1'b1;
        mac_op.a  = yhc_pkg::SMOOTH_NUM;
        mac_op.b  = yhc_pkg::mac_arg_t'(num_c);
      end
      S_SMOOTH_P: begin
        mac_op.en         = 1'b1;
        mac_op.accumulate = 1'b1;
        mac_op.a          = yhc_pkg::SMOOTH_PRIOR;
        mac_op.b          = yhc_pkg::mac_arg_t'(prior_drive);
      end
      S_DIVIDE: begin
        mac_op.en = 1'b1;
        mac_op.a  = $signed({2'b0, mag[19:1]});
        mac_op.b  = yhc_pkg::RECIP_25;
      end
      default: begin
        mac_op = '0;
      end
    endcase
  end

  // Sequencer, run state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      run_active    <= 1'b0;
      coarse_mode   <= 1'b1;
      settle_count  <= '0;
      elapsed_ticks <= '0;
      first_step    <= 1'b1;
      prior_error   <= '0;
      prior_drive   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            cmd   <= item.command;
            wrap  <= yhc_pkg::wrap_t'(target_heading) - yhc_pkg::wrap_t'(item.yaw_sample);
            state <= S_WRAP;
          end
        end
        // One full-turn correction per cycle until the error is within a half turn.
        S_WRAP: begin
          if (wrap > yhc_pkg::HALF_TURN) begin
            wrap <= wrap - yhc_pkg::FULL_TURN;
          end else if (wrap < yhc_pkg::NEG_HALF_TURN) begin
            wrap <= wrap + yhc_pkg::FULL_TURN;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          drive <= '0;
          if (cmd == yhc_pkg::CMD_START) begin
            coarse_mode   <= 1'b1;
            settle_count  <= '0;
            elapsed_ticks <= '0;
            first_step    <= 1'b1;
            prior_error   <= '0;
            prior_drive   <= '0;
            state         <= S_OUT;
            if (aerr <= yhc_pkg::TOL_COARSE) begin
              run_active <= 1'b0;
              status     <= yhc_pkg::STATUS_SKIPPED;
            end else begin
              run_active <= 1'b1;
              status     <= yhc_pkg::STATUS_RUNNING;
            end
          end else if (!run_active) begin
            status <= yhc_pkg::STATUS_IDLE;
            state  <= S_OUT;
          end else if (elapsed_ticks >= tick_limit) begin
            run_active <= 1'b0;
            status     <= yhc_pkg::STATUS_TIMED_OUT;
            state      <= S_OUT;
          end else begin
            settle_count <= settle_new;
            if (settled) begin
              run_active <= 1'b0;
              status     <= yhc_pkg::STATUS_SETTLED;
              state      <= S_OUT;
            end else begin
              // Gain schedule: fast, one switch tick, then precise.
              if (coarse_mode && (aerr > yhc_pkg::SWITCH_ERR)) begin
                kp <= yhc_pkg::KP5_FAST;
                kd <= yhc_pkg::KD5_FAST;
              end else if (coarse_mode) begin
                kp          <= yhc_pkg::KP5_SWITCH;
                kd          <= yhc_pkg::KD5_SWITCH;
                coarse_mode <= 1'b0;
              end else begin
                kp <= yhc_pkg::KP5_PRECISE;
                kd <= yhc_pkg::KD5_PRECISE;
              end
              elapsed_ticks <= elapsed_ticks + 16'd1;
              status        <= yhc_pkg::STATUS_RUNNING;
              if (first_step) begin
                first_step  <= 1'b0;
                prior_error <= err;
                prior_drive <= '0;
                state       <= S_OUT;
              end else begin
                state <= S_MUL_P;
              end
            end
          end
        end
        S_MUL_P: begin
          diff  <= yhc_pkg::diff_t'(err) - yhc_pkg::diff_t'(prior_error);
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          state <= S_CLAMP;
        end
        // Clamp the raw numerator to the 0.4 bound.
        S_CLAMP: begin
          if (mac_acc > yhc_pkg::NUM_MAX) begin
            num_c <= yhc_pkg::NUM_CLAMP;
          end else if (mac_acc < yhc_pkg::NUM_MIN) begin
            num_c <= yhc_pkg::NUM_CLAMP_NEG;
          end else begin
            num_c <= mac_acc[17:0];
          end
          state <= S_SMOOTH_N;
        end
        S_SMOOTH_N: begin
          state <= S_SMOOTH_P;
        end
        S_SMOOTH_P: begin
          state <= S_ROUND;
        end
        // Round half away from zero: divide |sum| + 25 by 50.
        S_ROUND: begin
          neg   <= acc_low[20];
          mag   <= acc_abs[19:0] + yhc_pkg::ROUND_BIAS;
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          prior_drive <= smooth;
          prior_error <= err;
          if (smooth > lim) begin
            drive <= lim;
          end else if (smooth < lim_neg) begin
            drive <= lim_neg;
          end else begin
            drive <= smooth;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_drive  <= drive;
            out_status <= status;
            out_err    <= err;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `YHC_ASSERT_IMPLIES(a_no_drive_unless_running, clk, rst,
    out_valid && (out_status != yhc_pkg::STATUS_RUNNING), out_drive == '0,
    "Drive is nonzero outside a running tick.")
  `YHC_ASSERT_IMPLIES(a_drive_limit, clk, rst, out_valid,
    (out_drive <= yhc_pkg::LIM_HIGH) && (out_drive >= yhc_pkg::NEG_LIM_HIGH),
    "Drive exceeds the output limit.")
  `YHC_ASSERT_IMPLIES(a_error_wrapped, clk, rst, out_valid,
    (out_err <= yhc_pkg::ERR_MAX) && (out_err >= yhc_pkg::ERR_MIN),
    "Heading error is outside one half turn.")
  `YHC_ASSERT_NEXT(a_busy_after_accept, clk, rst, item.valid && item.ready, !item.ready,
    "Second transaction accepted while busy.")
  `YHC_ASSERT_IMPLIES(a_first_step_count, clk, rst, (state == S_IDLE) && !first_step,
    elapsed_ticks != '0, "A PD step ran without counting a tick.")

endmodule
